[hw/rtl/dwr_pkg.sv]
// ----------------------------------------------------------------------------
// dwr_pkg
// Shared types and constants for the draw-without-replacement block.
// ----------------------------------------------------------------------------
package dwr_pkg;

    // Field widths of the words on the ports
    localparam int CNT_W     = 11;
    localparam int IDX_OUT_W = 10;
    localparam int RND_W     = 31;

    // Default pool depth and reset value of the pool size register
    localparam int          MAX_POOL_DEF  = 1024;
    localparam logic [10:0] POOL_SIZE_RST = 11'd1024;

    // Width of the divider step counter
    localparam int DIV_CNT_W = 5;

    // Action codes
    localparam logic ACT_DRAW    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    // Status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    // Input word
    typedef struct packed {
        logic             action;
        logic [RND_W-1:0] random_value;
    } dwr_in_t;

    // Result word
    typedef struct packed {
        logic [IDX_OUT_W-1:0] drawn_index;
        logic                 status;
        logic [CNT_W-1:0]     remaining_after;
    } dwr_out_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic clr_start;
        logic clr_step;
        logic refill_cnt;
        logic div_load;
        logic div_step;
        logic rd_last;
        logic rd_slot;
        logic swap;
        logic empty_res;
    } dwr_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic cnt_zero;
    } dwr_stat_t;

endpackage

[hw/rtl/dwr_ram.sv]
// ----------------------------------------------------------------------------
// dwr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dwr_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/dwr_ctrl.sv]
// ----------------------------------------------------------------------------
// dwr_ctrl
// Controller: sequences the clearing pass, the serial modulo, the two pool
// reads and the swap write.
// ----------------------------------------------------------------------------
module dwr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               action,
    input  dwr_pkg::dwr_stat_t stat,
    output dwr_pkg::dwr_cmd_t  cmd,
    output logic               busy
);

    import dwr_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_RD_LAST,
        S_RD_SLOT,
        S_SWAP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_RESTART)
                    begin
                        cmd.refill_cnt = 1'b1;
                        cmd.clr_start  = 1'b1;
                        state_next     = S_CLEAR;
                    end
                    else if (stat.cnt_zero)
                    begin
                        cmd.empty_res = 1'b1;
                    end
                    else
                    begin
                        cmd.div_load = 1'b1;
                        state_next   = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_RD_LAST;
                end
            end
            S_RD_LAST:
            begin
                cmd.rd_last = 1'b1;
                state_next  = S_RD_SLOT;
            end
            S_RD_SLOT:
            begin
                cmd.rd_slot = 1'b1;
                state_next  = S_SWAP;
            end
            S_SWAP:
            begin
                cmd.swap   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE);
    end

    // Hold state and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

[hw/rtl/dwr_dpath.sv]
// ----------------------------------------------------------------------------
// dwr_dpath
// Datapath: pool size register, live count, restoring modulo unit, pool RAM
// with its address muxing, and the result register.
// ----------------------------------------------------------------------------
module dwr_dpath #(
    parameter int MAX_POOL = dwr_pkg::MAX_POOL_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic [dwr_pkg::CNT_W-1:0]  cfg_data,
    input  dwr_pkg::dwr_in_t           item,
    input  dwr_pkg::dwr_cmd_t          cmd,
    output dwr_pkg::dwr_stat_t         stat,
    output logic                       result_valid,
    output dwr_pkg::dwr_out_t          result
);

    import dwr_pkg::*;

    localparam int IDX_W   = $clog2(MAX_POOL);
    localparam int WIDE_W  = IDX_W + CNT_W + IDX_OUT_W;
    localparam int RST_CNT = (MAX_POOL < 1024) ? MAX_POOL : 1024;

    logic [CNT_W-1:0]     pool_size_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [IDX_W-1:0]     clr_addr_reg;
    logic [RND_W-1:0]     rnd_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [IDX_W-1:0]     last_reg;
    logic                 valid_reg;
    dwr_out_t             result_reg;

    logic [CNT_W:0]       trial;
    logic [CNT_W-1:0]     rem_next;
    logic [CNT_W-1:0]     last_cnt;
    logic [WIDE_W-1:0]    slot_wide;
    logic [WIDE_W-1:0]    last_wide;
    logic [WIDE_W-1:0]    pick_wide;
    logic [IDX_W-1:0]     slot_addr;
    logic [IDX_W-1:0]     last_addr;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [IDX_W-1:0]     ram_wdata;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [IDX_W-1:0]     ram_rdata;

    // Pool size saturated to the pool depth
    always_comb
    begin
        if (32'(pool_size_reg) > MAX_POOL)
        begin
            cnt_next = CNT_W'(MAX_POOL);
        end
        else
        begin
            cnt_next = pool_size_reg;
        end
    end

    // One restoring step of value mod count
    assign trial = {rem_reg, rnd_reg[RND_W-1]};
    always_comb
    begin
        if (trial >= {1'b0, cnt_reg})
        begin
            rem_next = CNT_W'(trial - {1'b0, cnt_reg});
        end
        else
        begin
            rem_next = trial[CNT_W-1:0];
        end
    end

    // Resize count-domain values to RAM addresses and result indices
    assign last_cnt  = cnt_reg - 1'b1;
    assign slot_wide = WIDE_W'(rem_reg);
    assign last_wide = WIDE_W'(last_cnt);
    assign pick_wide = WIDE_W'(ram_rdata);
    assign slot_addr = slot_wide[IDX_W-1:0];
    assign last_addr = last_wide[IDX_W-1:0];

    // Status back to the controller
    assign stat.clr_last = (clr_addr_reg == IDX_W'(MAX_POOL - 1));
    assign stat.div_last = (div_cnt_reg == DIV_CNT_W'(RND_W - 1));
    assign stat.cnt_zero = (cnt_reg == '0);

    // Pool RAM ports: identity fill during clearing, swap write otherwise
    assign ram_we    = cmd.clr_step | cmd.swap;
    assign ram_waddr = cmd.clr_step ? clr_addr_reg : slot_addr;
    assign ram_wdata = cmd.clr_step ? clr_addr_reg : last_reg;
    assign ram_re    = cmd.rd_last | cmd.rd_slot;
    assign ram_raddr = cmd.rd_slot ? slot_addr : last_addr;

    dwr_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_POOL)
    ) u_pool_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control registers: pool size, live count, clear address, step counter, strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg <= POOL_SIZE_RST;
            cnt_reg       <= CNT_W'(RST_CNT);
            clr_addr_reg  <= '0;
            div_cnt_reg   <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                pool_size_reg <= cfg_data;
            end
            if (cmd.refill_cnt)
            begin
                cnt_reg <= cnt_next;
            end
            else if (cmd.swap)
            begin
                cnt_reg <= last_cnt;
            end
            if (cmd.clr_start)
            begin
                clr_addr_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.div_load)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            valid_reg <= cmd.swap | cmd.empty_res;
        end
    end

    // Payload registers: dividend, remainder, last entry, result word
    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rnd_reg <= item.random_value;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rnd_reg <= {rnd_reg[RND_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (cmd.rd_slot)
        begin
            last_reg <= ram_rdata;
        end
        if (cmd.swap)
        begin
            result_reg.drawn_index     <= pick_wide[IDX_OUT_W-1:0];
            result_reg.status          <= STATUS_OK;
            result_reg.remaining_after <= last_cnt;
        end
        else if (cmd.empty_res)
        begin
            result_reg.drawn_index     <= '0;
            result_reg.status          <= STATUS_EMPTY;
            result_reg.remaining_after <= '0;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

[hw/rtl/draw_without_replacement_top.sv]
// Draw: the 31-step modulo runs in S_DIV, then S_RD_LAST, S_RD_SLOT and S_SWAP follow
//   and the result strobe is registered after S_SWAP; no new word is taken until S_IDLE.
// Draw from an empty pool: result in the following cycle, one word per cycle.
// Restart: no result, busy while the pool RAM is refilled.
// Reset: pool size 1024, then busy during the identity fill; the receiver
//   cannot stall, each result strobe lasts exactly one cycle.
// ----------------------------------------------------------------------------
// draw_without_replacement_top
// Draws indices from a pool without replacement (Fisher-Yates style swap).
// ----------------------------------------------------------------------------
module draw_without_replacement_top #(
    parameter int MAX_POOL = dwr_pkg::MAX_POOL_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  dwr_pkg::dwr_in_t          item,
    output logic                      result_valid,
    output dwr_pkg::dwr_out_t         result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [dwr_pkg::CNT_W-1:0] cfg_data
);

    import dwr_pkg::*;

    dwr_cmd_t  cmd;
    dwr_stat_t stat;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    dwr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (item.action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    dwr_dpath #(
        .MAX_POOL (MAX_POOL)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
